// ----- rtl/dmp_pkg.sv -----
`default_nettype none

package dmp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] KIND_QUESTION = 2'd0;
  localparam logic [1:0] KIND_ANSWER   = 2'd1;
  localparam logic [1:0] KIND_DONE     = 2'd2;

  localparam logic [7:0] LABEL_PTR_MASK = 8'hc0;

  localparam logic [16:0] QUESTION_TAIL = 17'd5;
  localparam logic [16:0] ANSWER_TAIL   = 17'd12;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [4:0]  record_index;
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [31:0] ttl;
    logic [15:0] name_offset;
    logic [15:0] name_length;
    logic [15:0] rdata_length;
    logic [15:0] transaction_id;
    logic [15:0] header_flags;
    logic        status;
    logic        last_of_run;
  } result_t;

  // results of one byte, packed from r0 upward
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/dmp_in_if.sv -----
`default_nettype none

interface dmp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] packet_length;

  modport source(output valid, data_byte, packet_length, input ready);
  modport sink(input valid, data_byte, packet_length, output ready);
endinterface

`default_nettype wire

// ----- rtl/dmp_out_if.sv -----
`default_nettype none

interface dmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  item_kind;
  logic [4:0]  record_index;
  logic [15:0] record_type;
  logic [15:0] record_class;
  logic [31:0] ttl;
  logic [15:0] name_offset;
  logic [15:0] name_length;
  logic [15:0] rdata_length;
  logic [15:0] transaction_id;
  logic [15:0] header_flags;
  logic        status;
  logic        last_of_run;

  modport source(output valid, item_kind, record_index, record_type, record_class, ttl,
                 name_offset, name_length, rdata_length, transaction_id, header_flags,
                 status, last_of_run, input ready);
  modport sink(input valid, item_kind, record_index, record_type, record_class, ttl,
               name_offset, name_length, rdata_length, transaction_id, header_flags,
               status, last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/dmp_parse_core.sv -----
`default_nettype none

module dmp_parse_core #(
  parameter int unsigned MAX_QUESTIONS = 32,
  parameter int unsigned MAX_ANSWERS   = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  dmp_in_if.sink             in_ch,
  input  wire logic          room,
  output dmp_pkg::push_t     push
);
  import dmp_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR, PH_NAME, PH_PTR, PH_LABEL, PH_FIXED, PH_RDATA, PH_IDLE
  } phase_t;

  localparam logic [5:0] MAX_Q = 6'(MAX_QUESTIONS);
  localparam logic [5:0] MAX_A = 6'(MAX_ANSWERS);

  logic        s_valid_r, s_valid_nxt;
  logic [7:0]  s_byte_r;
  logic [15:0] s_len_r;
  logic        fire;

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [5:0]  q_left_r, q_left_nxt;
  logic [5:0]  a_left_r, a_left_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] name_start_r, name_start_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [15:0] type_r, type_nxt;
  logic [15:0] class_r, class_nxt;
  logic [31:0] ttl_r, ttl_nxt;
  logic [15:0] rdlen_r, rdlen_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] flags_r, flags_nxt;
  logic        err_r, err_nxt;

  logic        start_req, name_end_req, rec_v, done_v, tail_ok;
  logic [15:0] pos_inc;
  logic [16:0] need;
  result_t     rec, done;

  assign fire        = s_valid_r && room;
  assign in_ch.ready = !s_valid_r || room;
  assign pos_inc     = pos_r + 16'd1;

  always_comb begin
    s_valid_nxt = s_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      s_valid_nxt = 1'b1;
    end else if (fire) begin
      s_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    pos_nxt        = pos_inc;
    q_left_nxt     = q_left_r;
    a_left_nxt     = a_left_r;
    idx_nxt        = idx_r;
    name_start_nxt = name_start_r;
    skip_nxt       = skip_r;
    type_nxt       = type_r;
    class_nxt      = class_r;
    ttl_nxt        = ttl_r;
    rdlen_nxt      = rdlen_r;
    id_nxt         = id_r;
    flags_nxt      = flags_r;
    err_nxt        = err_r;
    start_req      = 1'b0;
    name_end_req   = 1'b0;
    rec_v          = 1'b0;
    rec            = '0;
    need           = (q_left_r != 6'd0) ? QUESTION_TAIL : ANSWER_TAIL;

    unique case (phase_r)
      PH_HDR: begin
        case (pos_r)
          16'd0:   id_nxt    = {s_byte_r, 8'h00};
          16'd1:   id_nxt    = {id_r[15:8], id_r[7:0] | s_byte_r};
          16'd2:   flags_nxt = {s_byte_r, 8'h00};
          16'd3:   flags_nxt = {flags_r[15:8], flags_r[7:0] | s_byte_r};
          16'd4:   type_nxt  = {s_byte_r, 8'h00};
          16'd5:   type_nxt  = {type_r[15:8], type_r[7:0] | s_byte_r};
          16'd6:   class_nxt = {s_byte_r, 8'h00};
          16'd7:   class_nxt = {class_r[15:8], class_r[7:0] | s_byte_r};
          16'd11: begin
            q_left_nxt = (type_r > 16'(MAX_Q)) ? MAX_Q : type_r[5:0];
            a_left_nxt = (class_r > 16'(MAX_A)) ? MAX_A : class_r[5:0];
            type_nxt   = '0;
            class_nxt  = '0;
            idx_nxt    = '0;
            start_req  = 1'b1;
          end
          default: ;
        endcase
      end
      PH_NAME: begin
        if (s_byte_r == 8'd0) begin
          name_end_req = 1'b1;
        end else if ((s_byte_r & LABEL_PTR_MASK) != 8'd0) begin
          phase_nxt = PH_PTR;
        end else begin
          skip_nxt  = {8'd0, s_byte_r};
          phase_nxt = PH_LABEL;
        end
      end
      PH_PTR: name_end_req = 1'b1;
      PH_LABEL: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == 16'd0) phase_nxt = PH_NAME;
      end
      PH_FIXED: begin
        if (skip_r == 16'd0) begin
          type_nxt = {s_byte_r, 8'h00};
        end else if (skip_r == 16'd1) begin
          type_nxt = {type_r[15:8], type_r[7:0] | s_byte_r};
        end else if (skip_r == 16'd2) begin
          class_nxt = {s_byte_r, 8'h00};
        end else if (skip_r == 16'd3) begin
          class_nxt = {class_r[15:8], class_r[7:0] | s_byte_r};
        end else if (skip_r <= 16'd7) begin
          ttl_nxt = {ttl_r[23:0], s_byte_r};
        end else if (skip_r == 16'd8) begin
          rdlen_nxt = {s_byte_r, 8'h00};
        end else begin
          rdlen_nxt = {rdlen_r[15:8], rdlen_r[7:0] | s_byte_r};
        end
        skip_nxt = skip_r + 16'd1;

        if (q_left_r != 6'd0 && skip_r >= 16'd3) begin
          rec_v             = 1'b1;
          rec.item_kind     = KIND_QUESTION;
          rec.record_index  = idx_r;
          rec.record_type   = type_nxt;
          rec.record_class  = class_nxt;
          rec.name_offset   = name_start_r;
          rec.name_length   = pos_r - name_start_r - 16'd3;
          q_left_nxt        = q_left_r - 6'd1;
          idx_nxt           = (q_left_nxt == 6'd0) ? 5'd0 : idx_r + 5'd1;
          start_req         = 1'b1;
        end else if (q_left_r == 6'd0 && skip_r >= 16'd9) begin
          rec_v             = 1'b1;
          rec.item_kind     = KIND_ANSWER;
          rec.record_index  = idx_r;
          rec.record_type   = type_nxt;
          rec.record_class  = class_nxt;
          rec.ttl           = ttl_nxt;
          rec.name_offset   = name_start_r;
          rec.name_length   = pos_r - name_start_r - 16'd9;
          rec.rdata_length  = rdlen_nxt;
          if (a_left_r != 6'd0) a_left_nxt = a_left_r - 6'd1;
          idx_nxt = idx_r + 5'd1;
          if (rdlen_nxt != 16'd0) begin
            skip_nxt  = rdlen_nxt;
            phase_nxt = PH_RDATA;
          end else begin
            start_req = 1'b1;
          end
        end
      end
      PH_RDATA: begin
        skip_nxt = skip_r - 16'd1;
        if (skip_nxt == 16'd0) start_req = 1'b1;
      end
      PH_IDLE: ;
      default: ;
    endcase

    // name ended: check room for the fixed part of the record
    if (name_end_req) begin
      if ({1'b0, pos_r} + need > {1'b0, s_len_r}) begin
        err_nxt   = 1'b1;
        phase_nxt = PH_IDLE;
      end else begin
        phase_nxt = PH_FIXED;
        skip_nxt  = '0;
        ttl_nxt   = '0;
        rdlen_nxt = '0;
      end
    end

    if (start_req) begin
      if ({1'b0, q_left_nxt} + {1'b0, a_left_nxt} != 7'd0) begin
        phase_nxt      = PH_NAME;
        name_start_nxt = pos_inc;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end

    done_v  = ({1'b0, pos_r} + 17'd1) >= {1'b0, s_len_r};
    tail_ok = (phase_nxt == PH_IDLE) ||
              (phase_nxt == PH_RDATA && q_left_nxt == 6'd0 && a_left_nxt == 6'd0);
    done                = '0;
    done.item_kind      = KIND_DONE;
    done.transaction_id = (phase_nxt == PH_HDR) ? 16'd0 : id_nxt;
    done.header_flags   = (phase_nxt == PH_HDR) ? 16'd0 : flags_nxt;
    done.status         = err_nxt || !tail_ok;
    done.last_of_run    = 1'b1;
    rec.last_of_run     = !done_v;

    // packet end puts everything back to the post-reset state
    if (done_v) begin
      phase_nxt      = PH_HDR;
      pos_nxt        = '0;
      q_left_nxt     = '0;
      a_left_nxt     = '0;
      idx_nxt        = '0;
      name_start_nxt = '0;
      skip_nxt       = '0;
      type_nxt       = '0;
      class_nxt      = '0;
      ttl_nxt        = '0;
      rdlen_nxt      = '0;
      id_nxt         = '0;
      flags_nxt      = '0;
      err_nxt        = 1'b0;
    end

    push.cnt = fire ? ({1'b0, rec_v} + {1'b0, done_v}) : 2'd0;
    push.r0  = rec_v ? rec : done;
    push.r1  = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r    <= 1'b0;
      phase_r      <= PH_HDR;
      pos_r        <= '0;
      q_left_r     <= '0;
      a_left_r     <= '0;
      idx_r        <= '0;
      name_start_r <= '0;
      skip_r       <= '0;
      type_r       <= '0;
      class_r      <= '0;
      ttl_r        <= '0;
      rdlen_r      <= '0;
      id_r         <= '0;
      flags_r      <= '0;
      err_r        <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
      if (fire) begin
        phase_r      <= phase_nxt;
        pos_r        <= pos_nxt;
        q_left_r     <= q_left_nxt;
        a_left_r     <= a_left_nxt;
        idx_r        <= idx_nxt;
        name_start_r <= name_start_nxt;
        skip_r       <= skip_nxt;
        type_r       <= type_nxt;
        class_r      <= class_nxt;
        ttl_r        <= ttl_nxt;
        rdlen_r      <= rdlen_nxt;
        id_r         <= id_nxt;
        flags_r      <= flags_nxt;
        err_r        <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s_byte_r <= in_ch.data_byte;
      s_len_r  <= in_ch.packet_length;
    end
  end

  a_two_ends_in_done: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> push.r1.item_kind == KIND_DONE && !push.r0.last_of_run)
    else $error("second result of a byte is not the done item");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd1 |-> push.r0.last_of_run)
    else $error("single result not marked last");

  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 && push.r0.item_kind == KIND_DONE
      |=> pos_r == 16'd0 && phase_r == PH_HDR && !err_r)
    else $error("state not cleared after packet end");

  a_fixed_has_records: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FIXED |-> q_left_r != 6'd0 || a_left_r != 6'd0)
    else $error("record fields parsed with no record left");

endmodule

`default_nettype wire

// ----- rtl/dmp_result_fifo.sv -----
`default_nettype none

module dmp_result_fifo (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  dmp_pkg::push_t push,
  output logic           room,
  dmp_out_if.source      out_ch
);
  import dmp_pkg::*;

  result_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic                    pop;
  result_t                 head;

  assign head = mem_r[rd_ptr_r];
  assign pop  = out_ch.valid && out_ch.ready;
  // two free slots cover the worst case of one byte
  assign room = count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2);

  assign out_ch.valid          = count_r != '0;
  assign out_ch.item_kind      = head.item_kind;
  assign out_ch.record_index   = head.record_index;
  assign out_ch.record_type    = head.record_type;
  assign out_ch.record_class   = head.record_class;
  assign out_ch.ttl            = head.ttl;
  assign out_ch.name_offset    = head.name_offset;
  assign out_ch.name_length    = head.name_length;
  assign out_ch.rdata_length   = head.rdata_length;
  assign out_ch.transaction_id = head.transaction_id;
  assign out_ch.header_flags   = head.header_flags;
  assign out_ch.status         = head.status;
  assign out_ch.last_of_run    = head.last_of_run;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + 1'b1] <= push.r1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room)
    else $error("results pushed without room");

endmodule

`default_nettype wire

// ----- rtl/dns_message_parser_unit.sv -----
`default_nettype none

// channel   dir  handshake      payload
// in_ch     in   valid/ready    data_byte, packet_length
// out_ch    out  valid/ready    one record or packet-done result per transfer
//
// one byte per cycle sustained while the queue has room; a byte goes through the input
// register and one pass of parse logic, and its results are written into a 4-entry result queue
// a byte may cause two results (last record and done) while the queue drains at
// most one per cycle, so the queue can fill while bytes keep coming in
// input stalls only when the queue has fewer than two free slots
// rst_n is synchronous; parser returns to header phase after every done result

module dns_message_parser_unit #(
  parameter int unsigned MAX_QUESTIONS = 32,
  parameter int unsigned MAX_ANSWERS   = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  dmp_in_if.sink     in_ch,
  dmp_out_if.source  out_ch
);
  import dmp_pkg::*;

  push_t push;
  logic  room;

  dmp_parse_core #(
    .MAX_QUESTIONS (MAX_QUESTIONS),
    .MAX_ANSWERS   (MAX_ANSWERS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  dmp_result_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ----- tb/dns_message_parser_unit_tb.sv -----
`timescale 1ns / 1ps

module dns_message_parser_unit_tb;
  import dmp_pkg::*;

  localparam int unsigned MAX_Q          = 32;
  localparam int unsigned MAX_A          = 32;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef enum logic [2:0] {
    PH_HEADER, PH_NAME, PH_POINTER, PH_LABEL, PH_FIXED, PH_RDATA, PH_IDLE
  } walk_phase_e;

  logic clk = 1'b0;
  logic rst_n;
  bit   sink_ready = 1'b0;
  bit   idling_on = 1'b0;
  int   sink_hold = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int unsigned bytes_sent = 0;

  dmp_in_if  in_bus ();
  dmp_out_if out_bus ();

  assign out_bus.ready = sink_ready;

  dns_message_parser_unit #(
    .MAX_QUESTIONS(MAX_Q),
    .MAX_ANSWERS  (MAX_A)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser state as the block should hold it
  walk_phase_e phase = PH_HEADER;
  int unsigned byte_count = 0, questions_due = 0, answers_due = 0, rec_index = 0;
  int unsigned name_base = 0, countdown = 0, type_word = 0, class_word = 0;
  int unsigned ttl_word = 0, rdlen_word = 0, txn_id = 0, flags_word = 0;
  bit          format_err = 1'b0;

  result_t     pending_items[$];
  logic [7:0]  packet_bytes[$];

  function automatic void parser_clear();
    phase = PH_HEADER;
    byte_count = 0; questions_due = 0; answers_due = 0; rec_index = 0;
    name_base = 0; countdown = 0; type_word = 0; class_word = 0;
    ttl_word = 0; rdlen_word = 0; txn_id = 0; flags_word = 0;
    format_err = 1'b0;
  endfunction

  function automatic void start_next(input int unsigned next_pos);
    if (questions_due + answers_due > 0) begin
      phase = PH_NAME;
      name_base = next_pos & 16'hffff;
    end else begin
      phase = PH_IDLE;
    end
  endfunction

  function automatic void close_name(input int unsigned e, input logic [15:0] len);
    int unsigned need;
    need = (questions_due != 0) ? QUESTION_TAIL : ANSWER_TAIL;
    if (e + need > len) begin
      format_err = 1'b1;
      phase = PH_IDLE;
    end else begin
      phase = PH_FIXED;
      countdown = 0;
      ttl_word = 0;
      rdlen_word = 0;
    end
  endfunction

  function automatic result_t make_record(input logic [1:0] kind, input int unsigned nlen);
    result_t r;
    r = '0;
    r.item_kind = kind;
    r.record_index = rec_index[4:0];
    r.record_type = type_word[15:0];
    r.record_class = class_word[15:0];
    r.name_offset = name_base[15:0];
    r.name_length = nlen[15:0];
    if (kind == KIND_ANSWER) begin
      r.ttl = ttl_word;
      r.rdata_length = rdlen_word[15:0];
    end
    return r;
  endfunction

  function automatic void parse_dns_byte(input logic [7:0] b, input logic [15:0] len);
    int unsigned pos, k;
    bit          have_rec, tail_ok;
    result_t     rec, fin;
    pos = byte_count;
    have_rec = 1'b0;
    rec = '0;
    case (phase)
      PH_HEADER: begin
        case (pos)
          0: txn_id = {b, 8'h00};
          1: txn_id |= b;
          2: flags_word = {b, 8'h00};
          3: flags_word |= b;
          4: type_word = {b, 8'h00};
          5: type_word |= b;
          6: class_word = {b, 8'h00};
          7: class_word |= b;
          11: begin
            questions_due = (type_word > MAX_Q) ? MAX_Q : type_word;
            answers_due = (class_word > MAX_A) ? MAX_A : class_word;
            type_word = 0;
            class_word = 0;
            rec_index = 0;
            start_next(pos + 1);
          end
          default: ;
        endcase
      end
      PH_NAME: begin
        if (b == 8'h00) close_name(pos, len);
        else if ((b & LABEL_PTR_MASK) != 8'h00) phase = PH_POINTER;
        else begin
          countdown = b;
          phase = PH_LABEL;
        end
      end
      PH_POINTER: close_name(pos, len);
      PH_LABEL: begin
        countdown = (countdown - 1) & 16'hffff;
        if (countdown == 0) phase = PH_NAME;
      end
      PH_FIXED: begin
        k = countdown;
        if (k == 0) type_word = {b, 8'h00};
        else if (k == 1) type_word |= b;
        else if (k == 2) class_word = {b, 8'h00};
        else if (k == 3) class_word |= b;
        else if (k <= 7) ttl_word = {ttl_word[23:0], b};
        else if (k == 8) rdlen_word = {b, 8'h00};
        else rdlen_word |= b;
        countdown = (k + 1) & 16'hffff;
        if (questions_due > 0 && k >= 3) begin
          rec = make_record(KIND_QUESTION, pos - 4 - name_base + 1);
          have_rec = 1'b1;
          questions_due--;
          rec_index = (rec_index + 1) & 31;
          if (questions_due == 0) rec_index = 0;
          start_next(pos + 1);
        end else if (questions_due == 0 && k >= 9) begin
          rec = make_record(KIND_ANSWER, pos - 10 - name_base + 1);
          have_rec = 1'b1;
          if (answers_due > 0) answers_due--;
          rec_index = (rec_index + 1) & 31;
          if (rdlen_word > 0) begin
            countdown = rdlen_word & 16'hffff;
            phase = PH_RDATA;
          end else begin
            start_next(pos + 1);
          end
        end
      end
      PH_RDATA: begin
        countdown = (countdown - 1) & 16'hffff;
        if (countdown == 0) start_next(pos + 1);
      end
      default: ;
    endcase

    if (pos + 1 >= len) begin
      fin = '0;
      fin.item_kind = KIND_DONE;
      // rdata of the final record may run off the end
      tail_ok = (phase == PH_IDLE) ||
                (phase == PH_RDATA && questions_due + answers_due == 0);
      if (phase != PH_HEADER) begin
        fin.transaction_id = txn_id[15:0];
        fin.header_flags = flags_word[15:0];
      end
      fin.status = format_err || !tail_ok;
      fin.last_of_run = 1'b1;
      if (have_rec) pending_items.push_back(rec);
      pending_items.push_back(fin);
      parser_clear();
    end else begin
      byte_count = (pos + 1) & 16'hffff;
      if (have_rec) begin
        rec.last_of_run = 1'b1;
        pending_items.push_back(rec);
      end
    end
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : item_compare
    result_t want;
    if (rst_n && in_bus.valid && in_bus.ready)
      parse_dns_byte(in_bus.data_byte, in_bus.packet_length);
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_items.size() == 0) begin
        $error("result transfer with nothing pending, item_kind %0d", out_bus.item_kind);
        mismatches++;
      end else begin
        want = pending_items.pop_front();
        check_field("item_kind", want.item_kind, out_bus.item_kind);
        check_field("record_index", want.record_index, out_bus.record_index);
        check_field("record_type", want.record_type, out_bus.record_type);
        check_field("record_class", want.record_class, out_bus.record_class);
        check_field("ttl", want.ttl, out_bus.ttl);
        check_field("name_offset", want.name_offset, out_bus.name_offset);
        check_field("name_length", want.name_length, out_bus.name_length);
        check_field("rdata_length", want.rdata_length, out_bus.rdata_length);
        check_field("transaction_id", want.transaction_id, out_bus.transaction_id);
        check_field("header_flags", want.header_flags, out_bus.header_flags);
        check_field("status", want.status, out_bus.status);
        check_field("last_of_run", want.last_of_run, out_bus.last_of_run);
      end
    end
  end

  // result side drops ready in random bursts while idling_on is set
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      sink_ready <= 1'b0;
      sink_hold <= $urandom_range(0, 7);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [15:0] len);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.packet_length <= len;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // last byte carries len; with inflate the others carry a random length of at least the packet size
  task automatic send_packet(input int unsigned len, input bit inflate);
    int unsigned i;
    logic [15:0] l;
    for (i = 0; i < packet_bytes.size(); i++) begin
      if (i + 1 != packet_bytes.size() && inflate)
        l = 16'($urandom_range(packet_bytes.size(), 65535));
      else
        l = len[15:0];
      send_byte(packet_bytes[i], l);
    end
  endtask

  task automatic add_word(input logic [15:0] w);
    packet_bytes.push_back(w[15:8]);
    packet_bytes.push_back(w[7:0]);
  endtask

  task automatic begin_packet(input logic [15:0] id, input logic [15:0] flags,
                              input logic [15:0] qd, input logic [15:0] an);
    packet_bytes.delete();
    add_word(id);
    add_word(flags);
    add_word(qd);
    add_word(an);
    repeat (4) packet_bytes.push_back(8'($urandom));
  endtask

  task automatic add_label(input int unsigned n);
    packet_bytes.push_back(n[7:0]);
    repeat (n) packet_bytes.push_back(8'($urandom));
  endtask

  // a nonzero end_byte makes the name end in a two-byte pointer
  task automatic add_name(input int unsigned labels, input logic [7:0] end_byte);
    repeat (labels)
      add_label(($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 5));
    packet_bytes.push_back(end_byte);
    if (end_byte != 8'h00) packet_bytes.push_back(8'($urandom));
  endtask

  task automatic add_question(input logic [15:0] rtype, input logic [15:0] rclass);
    add_word(rtype);
    add_word(rclass);
  endtask

  task automatic add_answer(input logic [15:0] rtype, input logic [15:0] rclass,
                            input logic [31:0] ttl, input logic [15:0] rdlen,
                            input int unsigned data_count);
    add_word(rtype);
    add_word(rclass);
    add_word(ttl[31:16]);
    add_word(ttl[15:0]);
    add_word(rdlen);
    repeat (data_count) packet_bytes.push_back(8'($urandom));
  endtask

  task automatic cut_packet(input int unsigned n);
    while (packet_bytes.size() > n) void'(packet_bytes.pop_back());
  endtask

  task automatic test_header_only();
    begin_packet(16'hffff, 16'hffff, 16'h0000, 16'h0000);
    send_packet(packet_bytes.size(), 0);
    begin_packet(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_packet(packet_bytes.size(), 0);
  endtask

  task automatic test_short_header();
    packet_bytes.delete();
    packet_bytes.push_back(8'hff);
    send_packet(1, 0);
    // zero length ends the packet on its first byte
    packet_bytes.delete();
    packet_bytes.push_back(8'h00);
    send_packet(0, 0);
    begin_packet(16'h1234, 16'h8180, 16'h0001, 16'h0000);
    cut_packet(11);
    send_packet(11, 0);
    // length shrinks on the last byte
    begin_packet(16'hbeef, 16'h0100, 16'h0000, 16'h0000);
    cut_packet(7);
    send_packet(3, 1);
  endtask

  task automatic test_name_forms();
    begin_packet(16'h0a0b, 16'h0100, 16'h0007, 16'h0000);
    add_name(0, 8'h00);
    add_question(16'h0000, 16'h0000);
    add_name(2, 8'h00);
    add_question(16'hffff, 16'hffff);
    add_name(0, 8'hc0);
    add_question(16'h0001, 16'h0001);
    add_name(1, 8'h40);
    add_question(16'h001c, 16'h00ff);
    add_name(0, 8'h80);
    add_question(16'h8000, 16'h8000);
    add_name(0, 8'hff);
    add_question(16'h00ff, 16'h0001);
    add_label(63);
    add_name(0, 8'h00);
    add_question(16'h0005, 16'h0001);
    send_packet(packet_bytes.size(), 0);
  endtask

  task automatic test_answers();
    begin_packet(16'h5a5a, 16'h8180, 16'h0001, 16'h0003);
    add_name(1, 8'h00);
    add_question(16'h0000, 16'hffff);
    add_name(0, 8'hc0);
    add_answer(16'hffff, 16'h0000, 32'hffffffff, 16'd4, 4);
    add_name(2, 8'h00);
    add_answer(16'h0001, 16'h0001, 32'h0, 16'd0, 0);
    // final rdata runs past the end, still fine
    add_name(0, 8'h00);
    add_answer(16'h001c, 16'h0001, 32'h00015180, 16'hffff, 3);
    send_packet(packet_bytes.size(), 0);
  endtask

  task automatic test_count_caps();
    begin_packet(16'h0001, 16'h0000, 16'hffff, 16'h0000);
    repeat (MAX_Q) begin
      add_name(0, 8'h00);
      add_question(16'($urandom), 16'($urandom));
    end
    send_packet(packet_bytes.size(), 0);
    begin_packet(16'h0002, 16'h8400, 16'h0000, 16'h0021);
    repeat (MAX_A) begin
      add_name(0, 8'h00);
      add_answer(16'($urandom), 16'($urandom), $urandom, 16'd0, 0);
    end
    send_packet(packet_bytes.size(), 0);
  endtask

  task automatic test_format_errors();
    // question fixed part does not fit
    begin_packet(16'h0101, 16'h0000, 16'h0001, 16'h0000);
    add_name(0, 8'h00);
    add_question(16'h0001, 16'h0001);
    cut_packet(packet_bytes.size() - 1);
    send_packet(packet_bytes.size(), 0);
    // answer fixed part does not fit
    begin_packet(16'h0202, 16'h0000, 16'h0000, 16'h0001);
    add_name(1, 8'h00);
    add_answer(16'h0001, 16'h0001, $urandom, 16'd0, 0);
    cut_packet(packet_bytes.size() - 1);
    send_packet(packet_bytes.size(), 0);
    // records left over
    begin_packet(16'h0303, 16'h0000, 16'h0002, 16'h0000);
    add_name(0, 8'h00);
    add_question(16'h0001, 16'h0001);
    send_packet(packet_bytes.size(), 0);
    begin_packet(16'h0404, 16'h0000, 16'h0001, 16'h0001);
    send_packet(packet_bytes.size(), 0);
    // ends inside rdata of a record that is not the last
    begin_packet(16'h0505, 16'h0000, 16'h0000, 16'h0002);
    add_name(0, 8'h00);
    add_answer(16'h0001, 16'h0001, $urandom, 16'd8, 8);
    add_name(0, 8'h00);
    add_answer(16'h0001, 16'h0001, $urandom, 16'd0, 0);
    cut_packet(26);
    send_packet(26, 1);
  endtask

  task automatic test_trailing_bytes();
    begin_packet(16'h0606, 16'h8180, 16'h0001, 16'h0001);
    add_name(1, 8'h00);
    add_question(16'h0001, 16'h0001);
    add_name(0, 8'hc0);
    add_answer(16'h0001, 16'h0001, $urandom, 16'd4, 4);
    repeat (4) packet_bytes.push_back(8'($urandom));
    send_packet(packet_bytes.size(), 0);
  endtask

  task automatic test_random_packets(input int unsigned budget, input bit with_idling);
    int unsigned stop_at, nq, na, hq, ha, i, n;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      idling_on <= with_idling && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise
        packet_bytes.delete();
        n = $urandom_range(1, 40);
        repeat (n) packet_bytes.push_back(8'($urandom));
        send_packet(packet_bytes.size(), 0);
      end else begin
        nq = $urandom_range(0, 3);
        na = $urandom_range(0, 3);
        hq = nq;
        ha = na;
        case ($urandom_range(0, 7))
          0: hq = nq + 1;
          1: ha = na + $urandom_range(1, 2);
          2: begin
            hq = $urandom_range(0, 65535);
            ha = $urandom_range(0, 65535);
          end
          default: ;
        endcase
        begin_packet(16'($urandom), 16'($urandom), hq[15:0], ha[15:0]);
        for (i = 0; i < nq; i++) begin
          add_name($urandom_range(0, 3),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom_range(64, 255)) : 8'h00);
          add_question(16'($urandom), 16'($urandom));
        end
        for (i = 0; i < na; i++) begin
          add_name($urandom_range(0, 3),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom_range(64, 255)) : 8'h00);
          if (i + 1 == na && $urandom_range(0, 3) == 0) begin
            add_answer(16'($urandom), 16'($urandom), $urandom,
                       16'($urandom_range(1, 65535)), $urandom_range(0, 3));
          end else begin
            n = $urandom_range(0, 6);
            add_answer(16'($urandom), 16'($urandom), $urandom, n[15:0], n);
          end
        end
        case ($urandom_range(0, 9))
          0: begin
            repeat ($urandom_range(1, 4)) packet_bytes.push_back(8'($urandom));
            send_packet(packet_bytes.size(), 0);
          end
          1: begin
            cut_packet($urandom_range(1, packet_bytes.size()));
            send_packet(packet_bytes.size(), 0);
          end
          2: begin
            cut_packet($urandom_range(1, packet_bytes.size()));
            send_packet(packet_bytes.size(), 1);
          end
          3: send_packet(packet_bytes.size(), 1);
          default: send_packet(packet_bytes.size(), 0);
        endcase
      end
    end
  endtask

  initial begin
    in_bus.valid <= 1'b0;
    in_bus.data_byte <= 8'h00;
    in_bus.packet_length <= 16'h0000;
    rst_n <= 1'b0;
    parser_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    idling_on <= 1'b1;

    test_header_only();
    test_short_header();
    test_name_forms();
    test_answers();
    test_count_caps();
    test_format_errors();
    test_trailing_bytes();
    test_random_packets(350, 1'b1);
    test_random_packets(100, 1'b0);

    in_bus.valid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
